// ----- src/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, codes, types and helper functions of the bitmap slot
// allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  // Store geometry.
  localparam int WORD_COUNT = 64;
  localparam int WORD_BITS  = 32;
  localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CNT_W      = $clog2(WORD_COUNT + 1);

  // Field widths.
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 11;
  localparam int STATUS_W = 2;
  localparam int BPW_W    = 6;
  localparam int NW_W     = 7;
  localparam int CFG_W    = 7;
  localparam int POS_W    = $clog2(WORD_BITS);
  localparam int BASE_W   = $clog2(WORD_COUNT * WORD_BITS) + 1;
  localparam int CMP_W    = IDX_W + CNT_W;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  // Divider: one quotient bit per step.
  localparam int DIV_STEPS = IDX_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_BPW = 1'b0;
  localparam logic CFG_NW  = 1'b1;

  // Result of the serial divider.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quot;
    logic [BPW_W-1:0] rem;
  } div_result_t;

  // Effective bits per word: zero acts as one, above the word width acts as full.
  function automatic logic [BPW_W-1:0] eff_bpw(input logic [BPW_W-1:0] raw);
    logic [BPW_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = BPW_W'(1);
    end else if (raw > BPW_W'(WORD_BITS)) begin
      res = BPW_W'(WORD_BITS);
    end
    return res;
  endfunction

  // Effective number of active words.
  function automatic logic [CNT_W-1:0] eff_words(input logic [NW_W-1:0] raw);
    logic [CNT_W-1:0] res;
    res = CNT_W'(raw);
    if (raw == '0) begin
      res = CNT_W'(1);
    end else if (int'(raw) > WORD_COUNT) begin
      res = CNT_W'(WORD_COUNT);
    end
    return res;
  endfunction

  // Mask of the low bpw bits of a word.
  function automatic logic [WORD_BITS-1:0] word_mask(input logic [BPW_W-1:0] bpw);
    logic [WORD_BITS-1:0] res;
    res = '1;
    if (int'(bpw) < WORD_BITS) begin
      res = (WORD_BITS'(1) << bpw) - WORD_BITS'(1);
    end
    return res;
  endfunction

  // Position of the lowest zero bit of a word.
  function automatic logic [POS_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] v);
    logic [POS_W-1:0] res;
    res = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        res = POS_W'(i);
      end
    end
    return res;
  endfunction

endpackage

// ----- src/bitmap_slot_allocator_core.sv -----
// Set, clear and read pass through the divider steps, quotient capture, store read,
// modify/write-back and output load; an out-of-range request skips the modify/write-back.
// Find-free scans at most the effective words_in_use store words: the scan reads one
// store word per cycle through the single read port of the bitmap RAM.
// One request is in flight at a time; one may wait as a result.
// Reset restores 32 bits per word and 64 words and marks every store word empty at once.
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_core
// Bitmap allocator with set, clear, read and find-first-free requests over a
// store of words kept in a synchronous RAM.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_core
  import bsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Configuration write port.
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  // Request stream.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,   // mode[1:0], bit_index[12:2], zero[15:13]
  // Result stream.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata    // status[1:0], bit_value[2], found_index[13:3],
                                      // zero[15:14]
);

  // Controller states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state;
  logic [BPW_W-1:0]      bits_per_word;
  logic [NW_W-1:0]       words_in_use;
  logic [WORD_COUNT-1:0] word_valid;

  logic [MODE_W-1:0]     op_mode;
  logic [IDX_W-1:0]      op_index;
  logic [IDX_W-1:0]      op_quot;
  logic [POS_W-1:0]      op_pos;
  logic                  mod_vld;

  logic [CNT_W-1:0]      scan_ptr;
  logic                  chk_en;
  logic                  chk_vld;
  logic [BASE_W-1:0]     chk_base;
  logic [BASE_W-1:0]     issue_base;

  logic [STATUS_W-1:0]   res_status;
  logic                  res_bit;
  logic [IDX_W-1:0]      res_found;

  logic [BPW_W-1:0]      bpw;
  logic [CNT_W-1:0]      nw;
  logic [WORD_BITS-1:0]  mask;
  logic                  div_start;
  div_result_t           div_res;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;

  logic [WORD_BITS-1:0]  mod_word;
  logic [WORD_BITS-1:0]  bit_sel;
  logic [WORD_BITS-1:0]  chk_word;
  logic                  chk_full;
  logic [BASE_W-1:0]     chk_found;
  logic                  out_free;
  logic                  in_range;

  // Effective configuration.
  always_comb begin
    bpw  = eff_bpw(bits_per_word);
    nw   = eff_words(words_in_use);
    mask = word_mask(bpw);
  end

  assign s_tready  = (state == S_IDLE);
  assign div_start = s_tvalid && s_tready && (s_tdata[1:0] != MODE_FIND);
  assign out_free  = !m_tvalid || m_tready;

  bsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_tdata[12:2]),
    .divisor  (bpw),
    .res      (div_res)
  );

  // Read-modify-write datapath.
  always_comb begin
    mod_word  = mod_vld ? ram_rdata : '0;
    bit_sel   = WORD_BITS'(1) << op_pos;
    chk_word  = (chk_vld ? ram_rdata : '0) & mask;
    chk_full  = (chk_word == mask);
    chk_found = chk_base + BASE_W'(lowest_zero(chk_word));
    in_range  = (CMP_W'(op_quot) < CMP_W'(nw));

    ram_we    = (state == S_MOD) && (op_mode != MODE_READ);
    ram_waddr = op_quot[ADDR_W-1:0];
    ram_wdata = (op_mode == MODE_SET) ? (mod_word | bit_sel) : (mod_word & ~bit_sel);
    ram_raddr = (state == S_FIND) ? scan_ptr[ADDR_W-1:0] : op_quot[ADDR_W-1:0];
  end

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_word <= BPW_W'(WORD_BITS);
      words_in_use  <= NW_W'(WORD_COUNT);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BPW: bits_per_word <= cfg_wdata[BPW_W-1:0];
        CFG_NW:  words_in_use  <= cfg_wdata[NW_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_valid <= '0;
      chk_en     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_mode    <= s_tdata[1:0];
            op_index   <= s_tdata[12:2];
            scan_ptr   <= '0;
            issue_base <= '0;
            chk_en     <= 1'b0;
            state      <= (s_tdata[1:0] == MODE_FIND) ? S_FIND : S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            op_quot <= div_res.quot;
            op_pos  <= div_res.rem[POS_W-1:0];
            state   <= S_ACC;
          end
        end
        S_ACC: begin
          // The read issued here returns the word in the next cycle.
          mod_vld    <= word_valid[op_quot[ADDR_W-1:0]];
          res_found  <= op_index;
          res_bit    <= 1'b0;
          if (in_range) begin
            res_status <= ST_OK;
            state      <= S_MOD;
          end else begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end
        end
        S_MOD: begin
          if (op_mode == MODE_READ) begin
            res_bit <= mod_word[op_pos];
          end else begin
            word_valid[op_quot[ADDR_W-1:0]] <= 1'b1;
          end
          state <= S_DONE;
        end
        S_FIND: begin
          // Check the word read last cycle while the next one is read.
          res_bit <= 1'b0;
          if (chk_en && !chk_full) begin
            if (chk_found > BASE_W'(IDX_MAX)) begin
              res_status <= ST_FULL;
              res_found  <= '0;
            end else begin
              res_status <= ST_OK;
              res_found  <= chk_found[IDX_W-1:0];
            end
            chk_en <= 1'b0;
            state  <= S_DONE;
          end else if (scan_ptr < nw) begin
            chk_en     <= 1'b1;
            chk_vld    <= word_valid[scan_ptr[ADDR_W-1:0]];
            chk_base   <= issue_base;
            issue_base <= issue_base + BASE_W'(bpw);
            scan_ptr   <= scan_ptr + CNT_W'(1);
          end else begin
            res_status <= ST_FULL;
            res_found  <= '0;
            chk_en     <= 1'b0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result valid: raised when a result is loaded, dropped when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= {2'b00, res_found, res_bit, res_status};
    end
  end

  // An accepted request always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != S_IDLE))
    else $error("request accepted but controller stayed idle");

  // The scan never runs past the active words.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |-> (scan_ptr <= nw))
    else $error("find scan ran past the active words");

  // The divider only finishes while the controller waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  // The store is written only for in-range set and clear requests.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (in_range && ((op_mode == MODE_SET) || (op_mode == MODE_CLEAR))))
    else $error("store written for an invalid request");

  // A new result appears only after the result stage.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the result stage");

endmodule

// ----- src/bsa_ram.sv -----
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bsa_div.sv -----
// ----------------------------------------------------------------------------
// bsa_div
// Restoring serial divider that splits a global bit index into a word number
// and a bit position, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsa_div
  import bsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IDX_W-1:0] dividend,
  input  logic [BPW_W-1:0] divisor,
  output div_result_t      res
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [IDX_W-1:0]     quot;
  logic [BPW_W-1:0]     rem;
  logic [BPW_W-1:0]     dsor;
  logic                 done;
  logic [BPW_W-1:0]     trial;
  logic                 qbit;

  // One restoring step: the remainder stays below the divisor, so it fits.
  always_comb begin
    trial = {rem[BPW_W-2:0], quot[IDX_W-1]};
    qbit  = (trial >= dsor);
  end

  // Step sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && !start && (count == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
        count <= count + DIV_CNT_W'(1);
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsor <= divisor;
    end else if (busy) begin
      quot <= {quot[IDX_W-2:0], qbit};
      rem  <= qbit ? (trial - dsor) : trial;
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap slot allocator core. A short table of
// requests and register writes covers reset contents, the index and register
// extremes, full and out-of-range answers and stray high bits. Random phases
// follow: each picks new register values and most often issues allocate pairs
// (find-free followed by a set of the returned index), mixed with frees, reads
// and noise. Every result is checked field by field against an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
  import bsa_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int MAX_GAP      = 17;
  localparam int DRAIN_CYCLES = WORD_COUNT + 16;

  // One result transfer, unpacked into its fields.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                bit_value;
    logic [IDX_W-1:0]    found_index;
  } alloc_result_t;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} plan_kind_t;

  // One row of the directed table.
  typedef struct packed {
    plan_kind_t        kind;
    logic              cfg_sel;
    logic [CFG_W-1:0]  cfg_val;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    bit                typed;
    alloc_result_t     want;
  } plan_row_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = CFG_BPW;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [15:0]       m_tdata;

  // Bench copy of the allocator state and registers.
  logic [WORD_BITS-1:0] slot_map [WORD_COUNT];
  logic [BPW_W-1:0]     bits_cfg  = BPW_W'(WORD_BITS);
  logic [NW_W-1:0]      words_cfg = NW_W'(WORD_COUNT);

  alloc_result_t pending_results[$];
  plan_row_t     plan[$];

  int unsigned error_count  = 0;
  int unsigned accepted     = 0;
  int unsigned results_seen = 0;
  int unsigned full_count   = 0;
  int unsigned range_count  = 0;
  int unsigned setting_count = 0;
  int unsigned cycle_count  = 0;
  int unsigned rx_wait      = 0;
  bit          tx_calm      = 1'b0;
  bit          rx_calm      = 1'b0;

  bitmap_slot_allocator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Effective register values after clamping.
  function automatic int unsigned active_bits();
    if (bits_cfg == '0) return 1;
    if (bits_cfg > BPW_W'(WORD_BITS)) return WORD_BITS;
    return bits_cfg;
  endfunction

  function automatic int unsigned active_words();
    if (words_cfg == '0) return 1;
    if (int'(words_cfg) > WORD_COUNT) return WORD_COUNT;
    return words_cfg;
  endfunction

  // Apply one request to the bench state and return the result it must give.
  function automatic alloc_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                  input logic [IDX_W-1:0] idx);
    int unsigned          bpw, nw, w, b, j, g;
    logic [WORD_BITS-1:0] mask, v;
    bit                   hit;
    alloc_result_t        r;
    bpw = active_bits();
    nw  = active_words();
    mask = (bpw >= WORD_BITS) ? '1 : ((32'h1 << bpw) - 32'h1);
    r.status      = ST_OK;
    r.bit_value   = 1'b0;
    r.found_index = idx;
    if (mode == MODE_FIND) begin
      // First word that is not full, judged on its low bits only.
      r.status      = ST_FULL;
      r.found_index = '0;
      hit = 1'b0;
      for (w = 0; w < nw && !hit; w++) begin
        v = slot_map[w] & mask;
        if (v != mask) begin
          hit = 1'b1;
          j = 0;
          while (j < bpw && v[j]) j++;
          g = w * bpw + j;
          if (g <= IDX_MAX) begin
            r.status      = ST_OK;
            r.found_index = g[IDX_W-1:0];
          end
        end
      end
    end else begin
      w = idx / bpw;
      b = idx % bpw;
      if (w >= nw) begin
        r.status = ST_RANGE;
      end else if (mode == MODE_SET) begin
        slot_map[w][b] = 1'b1;
      end else if (mode == MODE_CLEAR) begin
        slot_map[w][b] = 1'b0;
      end else begin
        r.bit_value = slot_map[w][b];
      end
    end
    return r;
  endfunction

  // Directed table rows.
  function automatic void plan_write(input logic sel, input logic [CFG_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_WRITE;
    row.cfg_sel = sel;
    row.cfg_val = val;
    plan.push_back(row);
  endfunction

  function automatic void plan_request(input logic [MODE_W-1:0] mode,
                                       input logic [IDX_W-1:0] idx);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.mode = mode;
    row.idx  = idx;
    plan.push_back(row);
  endfunction

  function automatic void plan_checked(input logic [MODE_W-1:0] mode,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [STATUS_W-1:0] status,
                                       input logic bitv,
                                       input logic [IDX_W-1:0] found);
    plan_row_t row;
    row = '0;
    row.kind  = ROW_REQUEST;
    row.mode  = mode;
    row.idx   = idx;
    row.typed = 1'b1;
    row.want.status      = status;
    row.want.bit_value   = bitv;
    row.want.found_index = found;
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // Compare one result transfer with the oldest expectation.
  task automatic check_result(input logic [15:0] data);
    alloc_result_t got, want;
    got.status      = data[1:0];
    got.bit_value   = data[2];
    got.found_index = data[13:3];
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result 0x%04h arrived with nothing expected", data));
    end else begin
      want = pending_results.pop_front();
      if (got.status != want.status)
        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  results_seen, got.status, want.status));
      if (got.bit_value != want.bit_value)
        report_mismatch($sformatf("result %0d bit_value %0d, expected %0d",
                                  results_seen, got.bit_value, want.bit_value));
      if (got.found_index != want.found_index)
        report_mismatch($sformatf("result %0d found_index %0d, expected %0d",
                                  results_seen, got.found_index, want.found_index));
    end
  endtask

  // Drive one request transfer after a random gap; predict once it is taken.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                              input bit typed, input alloc_result_t want,
                              output alloc_result_t pred);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    cfg_we <= 1'b0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, idx, mode};
    do @(posedge clk); while (!s_tready);
    pred = apply_request(mode, idx);
    if (pred.status == ST_FULL) full_count++;
    if (pred.status == ST_RANGE) range_count++;
    pending_results.push_back(typed ? want : pred);
    accepted++;
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write; the enable stays high until the next request lowers it.
  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    if (sel == CFG_BPW) bits_cfg = val[BPW_W-1:0];
    else words_cfg = val[NW_W-1:0];
  endtask

  // Result side: random stall after each transfer, checking on every transfer.
  always @(posedge clk) begin : result_sink
    int unsigned next_wait;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else begin
      next_wait = rx_wait;
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
        next_wait = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (next_wait != 0) begin
        m_tready <= 1'b0;
        rx_wait  <= next_wait - 1;
      end else begin
        m_tready <= 1'b1;
        rx_wait  <= 0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] run stopped after %0d cycles with %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus.
  initial begin : stimulus
    alloc_result_t    pred;
    alloc_result_t    none;
    int unsigned      goal, burst, choice, span, pick, sel;
    logic [CFG_W-1:0] bits_val, words_val;
    none = '0;
    foreach (slot_map[i]) slot_map[i] = '0;

    // Directed table: reset contents and the extremes.
    plan_checked(MODE_FIND, 11'd0, ST_OK, 1'b0, 11'd0);
    plan_checked(MODE_READ, 11'd2047, ST_OK, 1'b0, 11'd2047);
    plan_checked(MODE_SET, 11'd0, ST_OK, 1'b0, 11'd0);
    plan_request(MODE_FIND, 11'd0);
    plan_checked(MODE_SET, 11'd2047, ST_OK, 1'b0, 11'd2047);
    plan_checked(MODE_READ, 11'd2047, ST_OK, 1'b1, 11'd2047);
    plan_checked(MODE_CLEAR, 11'd2047, ST_OK, 1'b0, 11'd2047);
    plan_request(MODE_READ, 11'd2047);
    // One bit per word, two words: full store and indices beyond the words in use.
    plan_write(CFG_BPW, 7'd1);
    plan_write(CFG_NW, 7'd2);
    plan_checked(MODE_SET, 11'd1, ST_OK, 1'b0, 11'd1);
    plan_checked(MODE_FIND, 11'd2047, ST_FULL, 1'b0, 11'd0);
    plan_checked(MODE_SET, 11'd2, ST_RANGE, 1'b0, 11'd2);
    plan_checked(MODE_READ, 11'd2047, ST_RANGE, 1'b0, 11'd2047);
    plan_checked(MODE_CLEAR, 11'd0, ST_OK, 1'b0, 11'd0);
    plan_request(MODE_FIND, 11'd0);
    // Zero in both registers acts as one.
    plan_write(CFG_BPW, 7'd0);
    plan_write(CFG_NW, 7'd0);
    plan_checked(MODE_READ, 11'd1, ST_RANGE, 1'b0, 11'd1);
    plan_checked(MODE_FIND, 11'd0, ST_OK, 1'b0, 11'd0);
    // Oversized values are clamped to the word width and word count.
    plan_write(CFG_BPW, 7'h7F);
    plan_write(CFG_NW, 7'h7F);
    plan_request(MODE_READ, 11'd32);
    plan_request(MODE_FIND, 11'd1365);
    plan_request(MODE_SET, 11'd4);
    // Narrow words: bit 4 of word 0 is now a stray bit that find-free must ignore.
    plan_write(CFG_BPW, 7'd4);
    plan_write(CFG_NW, 7'd2);
    plan_request(MODE_SET, 11'd0);
    plan_request(MODE_SET, 11'd1);
    plan_request(MODE_SET, 11'd2);
    plan_request(MODE_SET, 11'd3);
    plan_request(MODE_FIND, 11'd682);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (s_tvalid || pending_results.size() != 0) wait_idle();
        write_reg(plan[i].cfg_sel, plan[i].cfg_val);
        setting_count++;
      end else begin
        send_request(plan[i].mode, plan[i].idx, plan[i].typed, plan[i].want, pred);
      end
    end

    // Random phases, each under a fresh register setting.
    goal = accepted + RANDOM_ITEMS;
    while (accepted < goal) begin
      wait_idle();
      sel = $urandom_range(0, 5);
      if (sel == 0) bits_val = 7'd0;
      else if (sel == 1) bits_val = 7'd1;
      else if (sel == 2) bits_val = CFG_W'(WORD_BITS);
      else if (sel == 3) bits_val = CFG_W'($urandom_range(33, 127));
      else if (sel == 4) bits_val = CFG_W'($urandom_range(1, 8));
      else bits_val = CFG_W'($urandom_range(1, 32));
      sel = $urandom_range(0, 5);
      if (sel == 0) words_val = 7'd0;
      else if (sel == 1) words_val = 7'd1;
      else if (sel == 2) words_val = CFG_W'(WORD_COUNT);
      else if (sel == 3) words_val = CFG_W'($urandom_range(65, 127));
      else if (sel == 4) words_val = CFG_W'($urandom_range(1, 8));
      else words_val = CFG_W'($urandom_range(1, 64));
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_BPW, bits_val);
        write_reg(CFG_NW, words_val);
      end else begin
        write_reg(CFG_NW, words_val);
        write_reg(CFG_BPW, bits_val);
      end
      setting_count++;
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(30, 120);

      repeat (burst) begin
        span = active_bits() * active_words();
        if (span > 2048) span = 2048;
        pick = $urandom_range(0, span - 1);
        choice = $urandom_range(0, 15);
        if (choice <= 4) begin
          // Allocate: find a free slot, then claim it.
          send_request(MODE_FIND, IDX_W'($urandom_range(0, 2047)), 1'b0, none, pred);
          if (pred.status == ST_OK)
            send_request(MODE_SET, pred.found_index, 1'b0, none, pred);
        end else if (choice <= 6) begin
          send_request(MODE_CLEAR, IDX_W'(pick), 1'b0, none, pred);
        end else if (choice <= 8) begin
          send_request(MODE_SET, IDX_W'(pick), 1'b0, none, pred);
        end else if (choice <= 10) begin
          send_request(MODE_READ, IDX_W'(pick), 1'b0, none, pred);
        end else if (choice == 11) begin
          send_request(MODE_FIND, IDX_W'(pick), 1'b0, none, pred);
        end else if (choice <= 13) begin
          send_request(MODE_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 2047)),
                       1'b0, none, pred);
        end else begin
          // Just past the last active word.
          pick = span + $urandom_range(0, 3);
          if (pick > 2047) pick = 2047;
          send_request(MODE_W'($urandom_range(0, 3)), IDX_W'(pick), 1'b0, none, pred);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d requests under %0d register settings; %0d results checked.",
             accepted, setting_count, results_seen);
    $display("Predicted %0d full-store answers and %0d out-of-range rejections.",
             full_count, range_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
